// File: rtl/bfs_pkg.sv
// shared types and constants for the burst-fire relay scheduler
// no dependencies; used by every module in rtl/
`timescale 1ns / 1ps

package bfs_pkg;

  // field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // serial arithmetic widths
  localparam int unsigned DIV_W = 32;  // dividend and quotient
  localparam int unsigned DVS_W = 16;  // divisor and remainder
  localparam int unsigned MUL_W = 16;  // both factors

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OFF   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAVE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_POL    = 2'd2;

  // register reset values and clamp limits
  localparam logic [CFG_W-1:0] WAVE_RST     = 16'd20;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] WAVE_MIN     = 16'd10;
  localparam logic [CFG_W-1:0] WAVE_DEFAULT = 16'd20;
  localparam logic [CFG_W-1:0] WINDOW_MIN   = 16'd20;

  // permille scale
  localparam logic [DUTY_W-1:0] PERMILLE_FULL = 16'd1000;
  localparam logic [DUTY_W-1:0] PERMILLE_HALF = 16'd500;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              enable;
    logic [DUTY_W-1:0] duty_req;
  } in_t;

  typedef struct packed {
    logic              output_on;
    logic              pin_level;
    logic              sched_en;
    logic [DUTY_W-1:0] duty_held;
  } out_t;

endpackage

// File: rtl/burst_fire_ssr_scheduler.sv
// burst-fire scheduler for a full-wave solid-state relay, top level
// depends on bfs_pkg, bfs_div and bfs_mul
`timescale 1ns / 1ps
//
//  channel   dir   handshake              payload
//  ------------------------------------------------------------------
//  cfg       in    cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//  in        in    in_valid_i/in_ready_o    in_data_i  (bfs_pkg::in_t)
//  out       out   out_valid_o/out_ready_i  out_data_o (bfs_pkg::out_t)
//
//  a tick, force-off, disabled apply, unused command or apply with duty 0 or
//  >= 1000 passes from the transfer cycle to the push step, which loads the
//  result; an apply with a partial duty runs the serial datapath: window /
//  wave, duty*waves and the rounding / 1000; unless the on-wave count is 0
//  or all waves, idx*count and / waves follow
//  reset leaves registers at 20 ms wave, 1000 ms window, active high, relay off
//  a result that is not taken holds only the push step: the next item is
//  accepted as soon as the result register has been loaded

module burst_fire_ssr_scheduler #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bfs_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bfs_pkg::out_t                 out_data_o
);

  localparam int unsigned CW = 33;  // compare width for phase vs window
  localparam int unsigned W  = bfs_pkg::CFG_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WAVES = 7'b0000010,
    S_MUL1  = 7'b0000100,
    S_ONW   = 7'b0001000,
    S_MUL2  = 7'b0010000,
    S_REM   = 7'b0100000,
    S_PUSH  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers, raw bits, clamped at use
  logic [W-1:0] cfg_wave_q, cfg_wave_d;
  logic [W-1:0] cfg_win_q, cfg_win_d;
  logic         cfg_ah_q, cfg_ah_d;

  // phase counter plus its split into wave index and ms within the wave
  logic [TIME_BITS-1:0] phase_q, phase_d;
  logic [W-1:0]         ms_q, ms_d;
  logic [W-1:0]         widx_q, widx_d;

  // relay state
  logic                       relay_q, relay_d;
  logic                       sched_q, sched_d;
  logic [bfs_pkg::DUTY_W-1:0] duty_q, duty_d;

  // datapath scratch
  logic [W-1:0] waves_q, waves_d;
  logic [W-1:0] on_q, on_d;

  // result register
  logic          out_valid_q, out_valid_d;
  bfs_pkg::out_t out_data_q, out_data_d;

  // effective wave and window
  logic [W-1:0] fw_eff, win_clamp, win_eff;
  assign fw_eff    = (cfg_wave_q < bfs_pkg::WAVE_MIN) ? bfs_pkg::WAVE_DEFAULT : cfg_wave_q;
  assign win_clamp = (cfg_win_q < bfs_pkg::WINDOW_MIN) ? bfs_pkg::WINDOW_MIN : cfg_win_q;
  assign win_eff   = (win_clamp < fw_eff) ? fw_eff : win_clamp;

  // tick arithmetic
  logic [TIME_BITS:0] phase_inc;
  logic               phase_wrap;
  logic [W-1:0]       ms_inc;
  assign phase_inc  = {1'b0, phase_q} + (TIME_BITS+1)'(1);
  assign phase_wrap = (CW'(phase_inc) >= CW'(win_eff)) || phase_inc[TIME_BITS];
  assign ms_inc     = ms_q + W'(1);

  // serial units
  logic                        div_start, div_done;
  logic [bfs_pkg::DIV_W-1:0]   div_dividend, div_quot;
  logic [bfs_pkg::DVS_W-1:0]   div_divisor, div_rem;
  logic                        mul_start, mul_done;
  logic [bfs_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [2*bfs_pkg::MUL_W-1:0] mul_prod;

  bfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  bfs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // waves is never zero since the window is at least one wave
  logic [W-1:0] waves_w;
  assign waves_w = (div_quot[W-1:0] == '0) ? W'(1) : div_quot[W-1:0];

  // a wave index in a partial last wave counts as the last whole wave
  logic [W-1:0] idx_w;
  assign idx_w = (widx_q >= waves_q) ? (waves_q - W'(1)) : widx_q;

  // bresenham step: hi > lo exactly when rem + on-wave count reaches waves
  logic step_on;
  assign step_on = ({1'b0, div_rem} + {1'b0, on_q}) >= {1'b0, waves_q};

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cfg_wave_d   = cfg_wave_q;
    cfg_win_d    = cfg_win_q;
    cfg_ah_d     = cfg_ah_q;
    phase_d      = phase_q;
    ms_d         = ms_q;
    widx_d       = widx_q;
    relay_d      = relay_q;
    sched_d      = sched_q;
    duty_d       = duty_q;
    waves_d      = waves_q;
    on_d         = on_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PUSH;
          case (in_data_i.command)
            bfs_pkg::CMD_TICK: begin
              if (phase_wrap) begin
                phase_d = '0;
                ms_d    = '0;
                widx_d  = '0;
              end else begin
                phase_d = phase_inc[TIME_BITS-1:0];
                if (ms_inc == fw_eff) begin
                  ms_d   = '0;
                  widx_d = widx_q + W'(1);
                end else begin
                  ms_d = ms_inc;
                end
              end
            end
            bfs_pkg::CMD_APPLY: begin
              if (!in_data_i.enable) begin
                sched_d = 1'b0;
                duty_d  = '0;
                relay_d = 1'b0;
              end else begin
                sched_d = 1'b1;
                duty_d  = in_data_i.duty_req;
                if (in_data_i.duty_req == '0) begin
                  relay_d = 1'b0;
                end else if (in_data_i.duty_req >= bfs_pkg::PERMILLE_FULL) begin
                  relay_d = 1'b1;
                end else begin
                  // waves = window / wave
                  div_start    = 1'b1;
                  div_dividend = bfs_pkg::DIV_W'(win_eff);
                  div_divisor  = fw_eff;
                  state_d      = S_WAVES;
                end
              end
            end
            bfs_pkg::CMD_OFF: begin
              sched_d = 1'b0;
              duty_d  = '0;
              relay_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_WAVES: begin
        if (div_done) begin
          waves_d   = waves_w;
          mul_start = 1'b1;
          mul_a     = duty_q;
          mul_b     = waves_w;
          state_d   = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          // rounded on-wave count = (duty * waves + 500) / 1000
          div_start    = 1'b1;
          div_dividend = mul_prod + bfs_pkg::DIV_W'(bfs_pkg::PERMILLE_HALF);
          div_divisor  = bfs_pkg::PERMILLE_FULL;
          state_d      = S_ONW;
        end
      end
      S_ONW: begin
        if (div_done) begin
          on_d = div_quot[W-1:0];
          if (div_quot[W-1:0] == '0) begin
            relay_d = 1'b0;
            state_d = S_PUSH;
          end else if (div_quot[W-1:0] >= waves_q) begin
            relay_d = 1'b1;
            state_d = S_PUSH;
          end else begin
            mul_start = 1'b1;
            mul_a     = idx_w;
            mul_b     = div_quot[W-1:0];
            state_d   = S_MUL2;
          end
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          div_start    = 1'b1;
          div_dividend = mul_prod;
          div_divisor  = waves_q;
          state_d      = S_REM;
        end
      end
      S_REM: begin
        if (div_done) begin
          relay_d = step_on;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_data_d.output_on = relay_q;
          out_data_d.pin_level = relay_q ^ ~cfg_ah_q;
          out_data_d.sched_en  = sched_q;
          out_data_d.duty_held = duty_q;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // register write restarts the phase
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bfs_pkg::CFG_IDX_WAVE: begin
          cfg_wave_d = cfg_data_i;
          phase_d    = '0;
          ms_d       = '0;
          widx_d     = '0;
        end
        bfs_pkg::CFG_IDX_WINDOW: begin
          cfg_win_d = cfg_data_i;
          phase_d   = '0;
          ms_d      = '0;
          widx_d    = '0;
        end
        bfs_pkg::CFG_IDX_POL: begin
          cfg_ah_d = cfg_data_i[0];
          phase_d  = '0;
          ms_d     = '0;
          widx_d   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_wave_q  <= bfs_pkg::WAVE_RST;
      cfg_win_q   <= bfs_pkg::WINDOW_RST;
      cfg_ah_q    <= 1'b1;
      phase_q     <= '0;
      ms_q        <= '0;
      widx_q      <= '0;
      relay_q     <= 1'b0;
      sched_q     <= 1'b0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_wave_q  <= cfg_wave_d;
      cfg_win_q   <= cfg_win_d;
      cfg_ah_q    <= cfg_ah_d;
      phase_q     <= phase_d;
      ms_q        <= ms_d;
      widx_q      <= widx_d;
      relay_q     <= relay_d;
      sched_q     <= sched_d;
      duty_q      <= duty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath scratch and result payload
  always_ff @(posedge clk_i) begin
    waves_q    <= waves_d;
    on_q       <= on_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // phase stays inside the effective window
  a_phase_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(phase_q) < CW'(win_eff))
    else $error("phase outside window");

  // ms counter stays inside one wave
  a_ms_in_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_q < fw_eff)
    else $error("ms counter outside wave");

  // divider results arrive only where the sequencer waits for them
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_WAVES || state_q == S_ONW || state_q == S_REM))
    else $error("divider done in wrong state");

  // relay is only on while the scheduler is enabled
  a_relay_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relay_q |-> sched_q)
    else $error("relay on while scheduler disabled");

  // a push with room loads the result register and returns to idle
  a_push_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && (!out_valid_q || out_ready_i)) |=>
      (out_valid_q && state_q == S_IDLE))
    else $error("push did not load result");

endmodule

// File: rtl/bfs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on bfs_pkg for operand widths
`timescale 1ns / 1ps

module bfs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bfs_pkg::DIV_W-1:0] dividend_i,
  input  logic [bfs_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bfs_pkg::DIV_W-1:0] quot_o,
  output logic [bfs_pkg::DVS_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(bfs_pkg::DIV_W);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [bfs_pkg::DIV_W-1:0] num_q, num_d;
  logic [bfs_pkg::DVS_W-1:0] den_q, den_d;
  logic [bfs_pkg::DVS_W-1:0] rem_q, rem_d;

  logic [bfs_pkg::DVS_W:0] shifted;
  logic [bfs_pkg::DVS_W:0] diff;
  logic                    ge;

  // shift in the next dividend bit and try one subtract
  assign shifted = {rem_q, num_q[bfs_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[bfs_pkg::DVS_W-1:0] : shifted[bfs_pkg::DVS_W-1:0];
      num_d = {num_q[bfs_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(bfs_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/bfs_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on bfs_pkg for operand widths
`timescale 1ns / 1ps

module bfs_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bfs_pkg::MUL_W-1:0]   a_i,
  input  logic [bfs_pkg::MUL_W-1:0]   b_i,
  output logic                        done_o,
  output logic [2*bfs_pkg::MUL_W-1:0] prod_o
);

  localparam int unsigned W     = bfs_pkg::MUL_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     a_q, a_d;
  logic [2*W-1:0]   p_q, p_d;

  logic [W:0] sum;

  // upper half accumulates, lower half shifts the multiplier out
  assign sum = {1'b0, p_q[2*W-1:W]} + {1'b0, a_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    p_d    = p_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      p_d    = {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      if (p_q[0]) begin
        p_d = {sum, p_q[W-1:1]};
      end else begin
        p_d = {1'b0, p_q[2*W-1:1]};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule
